// ===== src/motion_aligned_basis_matrix_defines.svh =====
// Assertion macros used by the motion-aligned basis matrix back end.
`ifndef MOTION_ALIGNED_BASIS_MATRIX_DEFINES_SVH
`define MOTION_ALIGNED_BASIS_MATRIX_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define MABM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mabm check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define MABM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mabm check failed");

`endif

// ===== src/mabm_pkg.sv =====
// Shared types and constants of the motion-aligned basis matrix.
package mabm_pkg;

    localparam int MABM_FRAC_BITS = 16;
    localparam int IN_QUEUE_DEPTH = 2;
    localparam int OUT_QUEUE_DEPTH = 4;

    localparam logic [63:0] NORM_HI = 64'h0000_0000_4000_0000;
    localparam logic [63:0] NORM_LO = 64'h0000_0000_2000_0000;

    localparam logic [1:0] ROW_FIRST = 2'd0;
    localparam logic [1:0] ROW_LAST = 2'd2;

    typedef enum logic [1:0] {
        CFG_SCALE_X = 2'd0,
        CFG_SCALE_Y = 2'd1,
        CFG_SCALE_Z = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } item_t;

    typedef struct packed {
        logic [1:0]         row_index;
        logic signed [31:0] col0;
        logic signed [31:0] col1;
        logic signed [31:0] col2;
        logic signed [31:0] col3;
        logic               last_row;
    } row_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== src/mabm_queue.sv =====
// Small register queue used between the front end, the back end and the result port.
module mabm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output mabm_pkg::q_status_t status
);
    import mabm_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNTW-1:0]  count_reg;
    logic             do_push;
    logic             do_pop;

    assign status.full = (count_reg == CNTW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop = pop && !status.empty;
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/mabm_front.sv =====
// Front end: takes input transactions, forms the direction and drops zero directions.
module mabm_front (
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] ref_x,
    input  logic signed [31:0] ref_y,
    input  logic signed [31:0] ref_z,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  mabm_pkg::q_status_t q_status,
    output logic               q_push,
    output mabm_pkg::item_t    q_item
);
    import mabm_pkg::*;

    logic zero_dir;

    always_comb
    begin
        q_item.dx = 33'(ref_x) - 33'(pos_x);
        q_item.dy = 33'(ref_y) - 33'(pos_y);
        q_item.dz = 33'(ref_z) - 33'(pos_z);
        q_item.px = pos_x;
        q_item.py = pos_y;
        q_item.pz = pos_z;
    end

    assign zero_dir = (ref_x == pos_x) && (ref_y == pos_y) && (ref_z == pos_z);
    assign full = q_status.full;
    assign q_push = push && !q_status.full && !zero_dir;

endmodule

// ===== src/mabm_back.sv =====
// Back end: normalizes the axes, forms the cross product and scales the three rows.
`include "motion_aligned_basis_matrix_defines.svh"

module mabm_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  mabm_pkg::q_status_t in_status,
    input  mabm_pkg::item_t    in_item,
    output logic               in_pop,
    input  mabm_pkg::q_status_t out_status,
    output logic               out_push,
    output mabm_pkg::row_t     out_row
);
    import mabm_pkg::*;

    localparam int CW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 2;
    localparam int QCW = $clog2(QW + 1);
    localparam int LW = 32;
    localparam int PW = 66;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_NINIT   = 14'b00000000000010,
        S_NSHIFT  = 14'b00000000000100,
        S_NSQ     = 14'b00000000001000,
        S_NACC    = 14'b00000000010000,
        S_SQRT    = 14'b00000000100000,
        S_DIVINIT = 14'b00000001000000,
        S_DIV     = 14'b00000010000000,
        S_NDONE   = 14'b00000100000000,
        S_CMUL    = 14'b00001000000000,
        S_CACC    = 14'b00010000000000,
        S_RMUL    = 14'b00100000000000,
        S_RACC    = 14'b01000000000000,
        S_PUSH    = 14'b10000000000000
    } state_t;

    typedef enum logic [2:0] {
        NT_FWD   = 3'b001,
        NT_RIGHT = 3'b010,
        NT_UP    = 3'b100
    } ntarget_t;

    state_t   state_reg, state_next;
    ntarget_t nsel_reg, nsel_next;
    logic [1:0]     idx_reg, idx_next;
    logic [2:0]     k_reg, k_next;
    logic [1:0]     row_reg, row_next;
    logic [QCW-1:0] cnt_reg, cnt_next;
    logic signed [31:0] scale_reg [3];

    logic signed [63:0]   vin_reg [3];
    logic                 neg_reg [3];
    logic [63:0]          mag_reg [3];
    logic [63:0]          mx_reg;
    logic [63:0]          sum_reg;
    logic [63:0]          sq_n_reg;
    logic [63:0]          sq_res_reg;
    logic [63:0]          sq_bit_reg;
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        rem_reg;
    logic [QW-1:0]        numlo_reg;
    logic [QW-1:0]        quo_reg;
    logic signed [CW-1:0] nout_reg [3];
    logic signed [CW-1:0] fw_reg [3];
    logic signed [CW-1:0] rt_reg [3];
    logic signed [CW-1:0] up_reg [3];
    logic signed [31:0]   pos_reg [3];
    logic signed [31:0]   col_reg [3];
    logic signed [PW-1:0] prod_reg;

    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [CW-1:0] ca;
    logic signed [CW-1:0] cb;
    logic signed [CW-1:0] rcomp;

    logic [63:0]   vmag [3];
    logic          vneg [3];
    logic [63:0]   vmx;
    logic [63:0]   sq_t;
    logic          sq_ge;
    logic [63:0]   sq_res_nx;
    logic [63:0]   sq_n_nx;
    logic [63:0]   div_num;
    logic [LW:0]   div_r2;
    logic          div_ge;
    logic [QW-1:0] quo_nx;
    logic          pneg;
    logic [PW-1:0] pmag;
    logic [PW-1:0] prnd;
    logic signed [31:0] sat_val;
    logic signed [CW-1:0] one_val;

    assign one_val = CW'(1 << FRAC_BITS);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vneg[i] = vin_reg[i][63];
            vmag[i] = vneg[i] ? 64'(-vin_reg[i]) : 64'(vin_reg[i]);
        end
        vmx = vmag[0];
        if (vmag[1] > vmx)
        begin
            vmx = vmag[1];
        end
        if (vmag[2] > vmx)
        begin
            vmx = vmag[2];
        end
    end

    always_comb
    begin
        sq_t = sq_res_reg + sq_bit_reg;
        sq_ge = (sq_n_reg >= sq_t);
        sq_n_nx = sq_ge ? (sq_n_reg - sq_t) : sq_n_reg;
        sq_res_nx = sq_ge ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);
    end

    always_comb
    begin
        div_num = (mag_reg[idx_reg] << FRAC_BITS) + 64'(len_reg >> 1);
        div_r2 = {rem_reg, numlo_reg[QW-1]};
        div_ge = (div_r2 >= {1'b0, len_reg});
        quo_nx = {quo_reg[QW-2:0], div_ge};
    end

    always_comb
    begin
        ca = '0;
        cb = '0;
        case (k_reg)
            3'd0:
            begin
                ca = fw_reg[1];
                cb = rt_reg[2];
            end
            3'd1:
            begin
                ca = fw_reg[2];
                cb = rt_reg[1];
            end
            3'd2:
            begin
                ca = fw_reg[2];
                cb = rt_reg[0];
            end
            3'd3:
            begin
                ca = fw_reg[0];
                cb = rt_reg[2];
            end
            3'd4:
            begin
                ca = fw_reg[0];
                cb = rt_reg[1];
            end
            3'd5:
            begin
                ca = fw_reg[1];
                cb = rt_reg[0];
            end
            default:
            begin
                ca = '0;
                cb = '0;
            end
        endcase

        case (idx_reg)
            2'd0:    rcomp = rt_reg[row_reg];
            2'd1:    rcomp = up_reg[row_reg];
            2'd2:    rcomp = fw_reg[row_reg];
            default: rcomp = '0;
        endcase

        case (state_reg)
            S_NSQ:
            begin
                mul_a = $signed({3'b000, mag_reg[idx_reg][29:0]});
                mul_b = $signed({3'b000, mag_reg[idx_reg][29:0]});
            end
            S_CMUL:
            begin
                mul_a = 33'(ca);
                mul_b = 33'(cb);
            end
            S_RMUL:
            begin
                mul_a = 33'(scale_reg[row_reg]);
                mul_b = 33'(rcomp);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
    end

    always_comb
    begin
        pneg = prod_reg[PW-1];
        pmag = pneg ? PW'(-prod_reg) : PW'(prod_reg);
        prnd = (pmag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (!pneg && (prnd > PW'(32'h7FFF_FFFF)))
        begin
            sat_val = 32'sh7FFF_FFFF;
        end
        else if (pneg && (prnd > PW'(32'h8000_0000)))
        begin
            sat_val = 32'sh8000_0000;
        end
        else
        begin
            sat_val = pneg ? -$signed(prnd[31:0]) : $signed(prnd[31:0]);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        nsel_next = nsel_reg;
        idx_next = idx_reg;
        k_next = k_reg;
        row_next = row_reg;
        cnt_next = cnt_reg;
        in_pop = 1'b0;
        out_push = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!in_status.empty)
                begin
                    in_pop = 1'b1;
                    nsel_next = NT_FWD;
                    state_next = S_NINIT;
                end
            end
            S_NINIT:
            begin
                state_next = (vmx == '0) ? S_NDONE : S_NSHIFT;
            end
            S_NSHIFT:
            begin
                if ((mx_reg < NORM_HI) && (mx_reg >= NORM_LO))
                begin
                    idx_next = '0;
                    state_next = S_NSQ;
                end
            end
            S_NSQ:
            begin
                state_next = S_NACC;
            end
            S_NACC:
            begin
                if (idx_reg == 2'd2)
                begin
                    state_next = S_SQRT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_NSQ;
                end
            end
            S_SQRT:
            begin
                if ((sq_bit_reg >> 2) == '0)
                begin
                    idx_next = '0;
                    state_next = S_DIVINIT;
                end
            end
            S_DIVINIT:
            begin
                cnt_next = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == QCW'(QW - 1))
                begin
                    if (idx_reg == 2'd2)
                    begin
                        state_next = S_NDONE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_DIVINIT;
                    end
                end
            end
            S_NDONE:
            begin
                case (nsel_reg)
                    NT_FWD:
                    begin
                        if ((nout_reg[2] == '0) && (nout_reg[0] == '0))
                        begin
                            row_next = ROW_FIRST;
                            idx_next = '0;
                            state_next = S_RMUL;
                        end
                        else
                        begin
                            nsel_next = NT_RIGHT;
                            state_next = S_NINIT;
                        end
                    end
                    NT_RIGHT:
                    begin
                        k_next = '0;
                        state_next = S_CMUL;
                    end
                    default:
                    begin
                        row_next = ROW_FIRST;
                        idx_next = '0;
                        state_next = S_RMUL;
                    end
                endcase
            end
            S_CMUL:
            begin
                state_next = S_CACC;
            end
            S_CACC:
            begin
                if (k_reg == 3'd5)
                begin
                    nsel_next = NT_UP;
                    state_next = S_NINIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = S_CMUL;
                end
            end
            S_RMUL:
            begin
                state_next = S_RACC;
            end
            S_RACC:
            begin
                if (idx_reg == 2'd2)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_RMUL;
                end
            end
            S_PUSH:
            begin
                if (!out_status.full)
                begin
                    out_push = 1'b1;
                    if (row_reg == ROW_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                        idx_next = '0;
                        state_next = S_RMUL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            nsel_reg <= NT_FWD;
            idx_reg <= '0;
            k_reg <= '0;
            row_reg <= '0;
            cnt_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                scale_reg[i] <= 32'(1 << FRAC_BITS);
            end
        end
        else
        begin
            state_reg <= state_next;
            nsel_reg <= nsel_next;
            idx_reg <= idx_next;
            k_reg <= k_next;
            row_reg <= row_next;
            cnt_reg <= cnt_next;
            if (cfg_valid)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SCALE_X: scale_reg[0] <= cfg_data;
                    CFG_SCALE_Y: scale_reg[1] <= cfg_data;
                    CFG_SCALE_Z: scale_reg[2] <= cfg_data;
                    default:     scale_reg[0] <= scale_reg[0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                vin_reg[0] <= 64'(in_item.dx);
                vin_reg[1] <= 64'(in_item.dy);
                vin_reg[2] <= 64'(in_item.dz);
                pos_reg[0] <= in_item.px;
                pos_reg[1] <= in_item.py;
                pos_reg[2] <= in_item.pz;
            end
            S_NINIT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= vmag[i];
                    neg_reg[i] <= vneg[i];
                    nout_reg[i] <= '0;
                end
                mx_reg <= vmx;
            end
            S_NSHIFT:
            begin
                if (mx_reg >= NORM_HI)
                begin
                    mx_reg <= mx_reg >> 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                else if (mx_reg < NORM_LO)
                begin
                    mx_reg <= mx_reg << 1;
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
                sum_reg <= '0;
            end
            S_NSQ:
            begin
                prod_reg <= mul_p;
            end
            S_NACC:
            begin
                sum_reg <= sum_reg + 64'(prod_reg);
                if (idx_reg == 2'd2)
                begin
                    sq_n_reg <= sum_reg + 64'(prod_reg);
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'h4000_0000_0000_0000;
                end
            end
            S_SQRT:
            begin
                sq_n_reg <= sq_n_nx;
                sq_res_reg <= sq_res_nx;
                sq_bit_reg <= sq_bit_reg >> 2;
                len_reg <= sq_res_nx[LW-1:0];
            end
            S_DIVINIT:
            begin
                rem_reg <= LW'(div_num >> QW);
                numlo_reg <= div_num[QW-1:0];
                quo_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= div_ge ? LW'(div_r2 - {1'b0, len_reg}) : div_r2[LW-1:0];
                numlo_reg <= numlo_reg << 1;
                quo_reg <= quo_nx;
                nout_reg[idx_reg] <= neg_reg[idx_reg] ? -$signed(CW'(quo_nx)) : $signed(CW'(quo_nx));
            end
            S_NDONE:
            begin
                case (nsel_reg)
                    NT_FWD:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            fw_reg[i] <= nout_reg[i];
                        end
                        rt_reg[0] <= one_val;
                        rt_reg[1] <= '0;
                        rt_reg[2] <= '0;
                        up_reg[0] <= '0;
                        up_reg[1] <= '0;
                        up_reg[2] <= one_val;
                        vin_reg[0] <= 64'(nout_reg[2]);
                        vin_reg[1] <= '0;
                        vin_reg[2] <= -64'(nout_reg[0]);
                    end
                    NT_RIGHT:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            rt_reg[i] <= nout_reg[i];
                        end
                    end
                    default:
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            up_reg[i] <= nout_reg[i];
                        end
                    end
                endcase
            end
            S_CMUL:
            begin
                prod_reg <= mul_p;
            end
            S_CACC:
            begin
                if (!k_reg[0])
                begin
                    vin_reg[k_reg[2:1]] <= 64'(prod_reg);
                end
                else
                begin
                    vin_reg[k_reg[2:1]] <= vin_reg[k_reg[2:1]] - 64'(prod_reg);
                end
            end
            S_RMUL:
            begin
                prod_reg <= mul_p;
            end
            S_RACC:
            begin
                col_reg[idx_reg] <= sat_val;
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    always_comb
    begin
        out_row.row_index = row_reg;
        out_row.col0 = col_reg[0];
        out_row.col1 = col_reg[1];
        out_row.col2 = col_reg[2];
        out_row.col3 = pos_reg[row_reg];
        out_row.last_row = (row_reg == ROW_LAST);
    end

    `MABM_ASSERT_NOW(a_norm_window, state_reg == S_NSQ, (mx_reg < NORM_HI) && (mx_reg >= NORM_LO))
    `MABM_ASSERT_NOW(a_len_range, state_reg == S_DIV, len_reg[LW-1:29] != '0)
    `MABM_ASSERT_NOW(a_rem_below_len, state_reg == S_DIV, rem_reg < len_reg)
    `MABM_ASSERT_NEXT(a_last_row_ends, out_push && (row_reg == ROW_LAST), state_reg == S_IDLE)

endmodule

// ===== src/motion_aligned_basis_matrix.sv =====
// Top level of the motion-aligned basis matrix block.
//
//  Channel   Handshake            Payload
//  input     push / full          ref_x ref_y ref_z pos_x pos_y pos_z
//  result    pop / empty          row_index col0 col1 col2 col3 last_row
//  config    cfg_valid/cfg_ready  cfg_index cfg_data
//
// In the back end an item needs one normalization when the direction is vertical
// and three otherwise. Each normalization is a shift into the normalization window,
// a 32-step square root and three FRAC_BITS+2 step divisions on one shared
// datapath. Each row then takes a multiply-and-round step per column and a push.
// A zero direction is dropped in the front end and produces no result.
// Reset clears the queues and sets every scale to one; cfg_ready is always high.
// Either side may stall freely; the input and result queues decouple them.
module motion_aligned_basis_matrix #(
    parameter int FRAC_BITS = mabm_pkg::MABM_FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] ref_x,
    input  logic signed [31:0] ref_y,
    input  logic signed [31:0] ref_z,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         row_index,
    output logic signed [31:0] col0,
    output logic signed [31:0] col1,
    output logic signed [31:0] col2,
    output logic signed [31:0] col3,
    output logic               last_row,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import mabm_pkg::*;

    q_status_t in_status;
    q_status_t out_status;
    logic      in_push;
    logic      in_pop;
    logic      out_push;
    item_t     in_wdata;
    item_t     in_rdata;
    row_t      out_wdata;
    row_t      out_rdata;

    assign cfg_ready = 1'b1;

    mabm_front u_front (
        .push     (push),
        .full     (full),
        .ref_x    (ref_x),
        .ref_y    (ref_y),
        .ref_z    (ref_z),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_z    (pos_z),
        .q_status (in_status),
        .q_push   (in_push),
        .q_item   (in_wdata)
    );

    mabm_queue #(
        .WIDTH ($bits(item_t)),
        .DEPTH (IN_QUEUE_DEPTH)
    ) u_in_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (in_push),
        .wdata  (in_wdata),
        .pop    (in_pop),
        .rdata  (in_rdata),
        .status (in_status)
    );

    mabm_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_status  (in_status),
        .in_item    (in_rdata),
        .in_pop     (in_pop),
        .out_status (out_status),
        .out_push   (out_push),
        .out_row    (out_wdata)
    );

    mabm_queue #(
        .WIDTH ($bits(row_t)),
        .DEPTH (OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (out_push),
        .wdata  (out_wdata),
        .pop    (pop),
        .rdata  (out_rdata),
        .status (out_status)
    );

    assign empty = out_status.empty;
    assign row_index = out_rdata.row_index;
    assign col0 = out_rdata.col0;
    assign col1 = out_rdata.col1;
    assign col2 = out_rdata.col2;
    assign col3 = out_rdata.col3;
    assign last_row = out_rdata.last_row;

endmodule

// ===== tb/sv/tb_motion_aligned_basis_matrix.sv =====
// Self-checking testbench of the motion-aligned basis matrix block.
`timescale 1ns / 100ps

module tb_motion_aligned_basis_matrix;
    import mabm_pkg::*;

    typedef longint vec3_t [3];

    localparam int FB = MABM_FRAC_BITS;
    localparam longint ONE = longint'(1) << FB;
    localparam int DRAIN_CYCLES = 600;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic signed [31:0] ref_x, ref_y, ref_z, pos_x, pos_y, pos_z;
    logic               empty;
    logic               pop;
    logic [1:0]         row_index;
    logic signed [31:0] col0, col1, col2, col3;
    logic               last_row;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    longint scale_reg [3];
    row_t   pending_rows [$];
    int     mismatches;
    bit     no_idle;

    motion_aligned_basis_matrix dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .ref_x(ref_x), .ref_y(ref_y), .ref_z(ref_z),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .empty(empty), .pop(pop), .row_index(row_index),
        .col0(col0), .col1(col1), .col2(col2), .col3(col3), .last_row(last_row),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic vec3_t unit_vector(input vec3_t v);
        vec3_t o;
        longint unsigned mag [3];
        longint unsigned mx, sum, len, q;
        mx = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] > mx)
                mx = mag[i];
        end
        if (mx == 0)
        begin
            o[0] = 0;
            o[1] = 0;
            o[2] = 0;
            return o;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx >>= 1;
            for (int i = 0; i < 3; i++)
                mag[i] >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += mag[i] * mag[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << FB) + (len >> 1)) / len;
            o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
        return o;
    endfunction

    function automatic logic signed [31:0] scaled_entry(input longint s, input longint c);
        longint p, r;
        longint unsigned m;
        p = s * c;
        m = p < 0 ? longint'(-p) : longint'(p);
        m = (m + (64'd1 << (FB - 1))) >> FB;
        r = p < 0 ? -longint'(m) : longint'(m);
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic predict_basis(input logic signed [31:0] rv [3],
                                 input logic signed [31:0] pv [3]);
        vec3_t d, fw, rt, up, tmp;
        row_t  row;
        for (int i = 0; i < 3; i++)
            d[i] = longint'(rv[i]) - longint'(pv[i]);
        if (d[0] == 0 && d[1] == 0 && d[2] == 0)
            return;
        fw = unit_vector(d);
        if (fw[2] == 0 && fw[0] == 0)
        begin
            rt[0] = ONE;
            rt[1] = 0;
            rt[2] = 0;
            up[0] = 0;
            up[1] = 0;
            up[2] = ONE;
        end
        else
        begin
            tmp[0] = fw[2];
            tmp[1] = 0;
            tmp[2] = -fw[0];
            rt = unit_vector(tmp);
            tmp[0] = fw[1] * rt[2] - fw[2] * rt[1];
            tmp[1] = fw[2] * rt[0] - fw[0] * rt[2];
            tmp[2] = fw[0] * rt[1] - fw[1] * rt[0];
            up = unit_vector(tmp);
        end
        for (int i = 0; i < 3; i++)
        begin
            row.row_index = 2'(i);
            row.col0 = scaled_entry(scale_reg[i], rt[i]);
            row.col1 = scaled_entry(scale_reg[i], up[i]);
            row.col2 = scaled_entry(scale_reg[i], fw[i]);
            row.col3 = pv[i];
            row.last_row = (2'(i) == ROW_LAST);
            pending_rows.push_back(row);
        end
    endtask

    always @(negedge clk)
        pop <= no_idle ? 1'b1 : ($urandom_range(99) >= 22);

    always @(posedge clk)
    begin
        row_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_rows.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected row, expected none, actual row_index %0d",
                         $time, row_index);
            end
            else
            begin
                want = pending_rows.pop_front();
                if (row_index !== want.row_index || col0 !== want.col0 ||
                    col1 !== want.col1 || col2 !== want.col2 ||
                    col3 !== want.col3 || last_row !== want.last_row)
                begin
                    mismatches++;
                    $display("%0t: row mismatch, expected %0d %0d %0d %0d %0d %0b",
                             $time, want.row_index, want.col0, want.col1,
                             want.col2, want.col3, want.last_row);
                    $display("%0t:               actual   %0d %0d %0d %0d %0d %0b",
                             $time, row_index, col0, col1, col2, col3, last_row);
                end
            end
        end
    end

    task automatic send_item(input logic signed [31:0] rx, ry, rz, px, py, pz);
        logic signed [31:0] rv [3];
        logic signed [31:0] pv [3];
        while (!no_idle && $urandom_range(99) < 22)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        ref_x <= rx;
        ref_y <= ry;
        ref_z <= rz;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        @(posedge clk);
        while (full)
            @(posedge clk);
        rv = '{rx, ry, rz};
        pv = '{px, py, pz};
        predict_basis(rv, pv);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_rows.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_scale(input cfg_index_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        scale_reg[idx] = longint'(signed'(value));
        @(negedge clk);
    endtask

    task automatic write_scales(input logic [31:0] sx, sy, sz);
        wait_idle();
        write_scale(CFG_SCALE_X, sx);
        write_scale(CFG_SCALE_Y, sy);
        write_scale(CFG_SCALE_Z, sz);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random(input int mode);
        logic signed [31:0] rx, ry, rz, px, py, pz;
        int span;
        px = $urandom;
        py = $urandom;
        pz = $urandom;
        span = $urandom_range(31, 1);
        rx = px + (signed'($urandom) >>> span);
        ry = py + (signed'($urandom) >>> span);
        rz = pz + (signed'($urandom) >>> span);
        case (mode)
            0: begin rx = $urandom; ry = $urandom; rz = $urandom; end
            1: begin rx = px; ry = py; rz = pz; end
            2: begin rx = px; rz = pz; end
            3: begin rx = px + $urandom_range(3); rz = pz - $urandom_range(3); end
            default: ;
        endcase
        send_item(rx, ry, rz, px, py, pz);
    endtask

    task automatic test_directed();
        send_item(0, 0, 0, 0, 0, 0);
        send_item(32'sh7FFF_FFFF, 5, -9, 32'sh7FFF_FFFF, 5, -9);
        send_item(0, 32'sd65536, 0, 0, 0, 0);
        send_item(0, -32'sd300000, 0, 0, 0, 0);
        send_item(32'sd65536, 0, 0, 0, 0, 0);
        send_item(0, 0, -32'sd65536, 0, 0, 0);
        send_item(1, 0, 0, 0, 0, 0);
        send_item(0, 0, 1, 0, 0, 0);
        send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_item(1, 32'sh7FFF_FFFF, -1, 0, 32'sh8000_0000, 0);
        send_item(32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 0, 0);
        send_item(3, -7, 11, -5, 2, 8);
        send_item(-32'sd131072, 32'sd65536, 32'sd196608, 32'sd10, -32'sd20, 32'sd30);
    endtask

    task automatic test_scale_extremes();
        write_scales(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        test_directed();
        write_scales(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000);
        test_directed();
    endtask

    task automatic test_random_items();
        for (int i = 0; i < 360; i++)
        begin
            if (i % 90 == 0)
                write_scales($urandom, $urandom_range(32'h0004_0000),
                             -$urandom_range(32'h0004_0000));
            no_idle = (i >= 180 && i < 240);
            send_random($urandom_range(9));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SCALE_X;
        cfg_data = '0;
        ref_x = '0;
        ref_y = '0;
        ref_z = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        mismatches = 0;
        no_idle = 1'b0;
        for (int i = 0; i < 3; i++)
            scale_reg[i] = ONE;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_scale_extremes();
        test_random_items();
        wait_idle();
        if (mismatches == 0 && pending_rows.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/mabm_pkg.sv
src/mabm_queue.sv
src/mabm_front.sv
src/mabm_back.sv
src/motion_aligned_basis_matrix.sv
tb/sv/tb_motion_aligned_basis_matrix.sv
